// ===== src/line_pixel_rasterizer_top_macros.svh =====
// Assertion macros for the line pixel rasterizer.
`ifndef LINE_PIXEL_RASTERIZER_TOP_MACROS_SVH
`define LINE_PIXEL_RASTERIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define LPR_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lpr: assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define LPR_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("lpr: next-cycle assertion failed");

`else

`define LPR_ASSERT(label, prop)
`define LPR_ASSERT_NEXT(label, trig, cond)

`endif

`endif

// ===== src/lpr_pkg.sv =====
// Shared constants for the line pixel rasterizer.
`default_nettype none

package lpr_pkg;

	// Coordinate width of both axes.
	localparam int COORD_BITS = 6;
	// Width of the colour word.
	localparam int COLOUR_BITS = 32;
	// Signed error term: holds values in (-dmaj, 3*dmaj].
	localparam int ERR_W = COORD_BITS + 3;

endpackage

`default_nettype wire

// ===== src/lpr_if.sv =====
// Handshake interfaces for line commands and pixel beats.
`default_nettype none

interface lpr_cmd_if;
	import lpr_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [COORD_BITS-1:0]  start_x;
	logic [COORD_BITS-1:0]  start_y;
	logic [COORD_BITS-1:0]  end_x;
	logic [COORD_BITS-1:0]  end_y;
	logic [COLOUR_BITS-1:0] colour;

	modport source (
		output valid, start_x, start_y, end_x, end_y, colour,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_y, end_x, end_y, colour,
		output ready
	);
endinterface

interface lpr_pix_if;
	import lpr_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [COORD_BITS-1:0]  pixel_x;
	logic [COORD_BITS-1:0]  pixel_y;
	logic [COLOUR_BITS-1:0] pixel_colour;
	logic                   last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, pixel_colour, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, pixel_colour, last_pixel,
		output ready
	);
endinterface

`default_nettype wire

// ===== src/line_pixel_rasterizer_top.sv =====
// Integer Bresenham line rasterizer: one line command in, a run of pixel beats out.
//
// A line command is taken when cmd.ready is high, which is only while the
// sequencer is idle. After the accepting cycle the block passes through the
// setup states ST_DELTA (axis swap for steep lines) and ST_ORDER (endpoint
// ordering and deltas), and then steps the shared error adder once per pixel
// along the major axis, emitting one pixel beat per cycle unless pix.ready
// stalls it. A command with major delta D gives D pixel beats, the last one
// flagged by last_pixel. cmd.ready stays low until the last beat is loaded,
// so a new command is taken only once the previous run is through; equal
// endpoints give no beats. The endpoint with the higher major coordinate
// is never emitted. The last pixel sits in an output register, so the next
// command can be accepted while it waits.
`default_nettype none
`include "line_pixel_rasterizer_top_macros.svh"

module line_pixel_rasterizer_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lpr_cmd_if.sink    cmd,
	lpr_pix_if.source  pix
);
	import lpr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DELTA = 4'b0010,
		ST_ORDER = 4'b0100,
		ST_RUN   = 4'b1000
	} lpr_state_t;

	lpr_state_t state_q;

	// Command registers; endpoint slots hold raw, then major/minor values; bmaj_q then holds the ordered end.
	logic [COORD_BITS-1:0]  amaj_q, amin_q, bmaj_q, bmin_q;
	logic [COLOUR_BITS-1:0] colour_q;
	logic                   steep_q;

	// Stepping registers.
	logic [COORD_BITS-1:0]  pos_q, minor_q, dmaj_q, dmin_q;
	logic                   step_down_q;
	logic signed [ERR_W-1:0] err_q;

	// Output register.
	logic                   pix_valid_q;
	logic [COORD_BITS-1:0]  pix_x_q, pix_y_q;
	logic [COLOUR_BITS-1:0] pix_colour_q;
	logic                   pix_last_q;

	// Setup logic.
	logic [COORD_BITS-1:0]  adx, ady;
	logic                   steep;
	logic                   swap_ends;
	logic [COORD_BITS-1:0]  lo_maj, lo_min, hi_maj, hi_min;

	// Run logic.
	logic                    cmd_fire;
	logic                    out_free;
	logic                    out_load;
	logic [COORD_BITS-1:0]   pos_inc;
	logic                    at_last;
	logic signed [ERR_W-1:0] dmin2, dmaj2, dmaj_ext, err_add;
	logic                    minor_step;
	logic [COORD_BITS-1:0]   minor_next;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;

	// Absolute deltas of the raw endpoints; ties count as shallow.
	assign adx   = (bmaj_q > amaj_q) ? bmaj_q - amaj_q : amaj_q - bmaj_q;
	assign ady   = (bmin_q > amin_q) ? bmin_q - amin_q : amin_q - bmin_q;
	assign steep = ady > adx;

	// Order endpoints so the major coordinate rises.
	assign swap_ends = amaj_q > bmaj_q;
	assign lo_maj    = swap_ends ? bmaj_q : amaj_q;
	assign lo_min    = swap_ends ? bmin_q : amin_q;
	assign hi_maj    = swap_ends ? amaj_q : bmaj_q;
	assign hi_min    = swap_ends ? amin_q : bmin_q;

	// Shared error adder and compare.
	assign dmin2      = $signed({2'b00, dmin_q, 1'b0});
	assign dmaj2      = $signed({2'b00, dmaj_q, 1'b0});
	assign dmaj_ext   = $signed({3'b000, dmaj_q});
	assign err_add    = err_q + dmin2;
	assign minor_step = err_add > dmaj_ext;
	assign minor_next = step_down_q ? minor_q - 1'b1 : minor_q + 1'b1;

	assign pos_inc  = pos_q + 1'b1;
	assign at_last  = pos_inc == bmaj_q;
	assign out_free = !pix_valid_q || pix.ready;
	assign out_load = (state_q == ST_RUN) && out_free;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) state_q <= ST_DELTA;
				end
				ST_DELTA: begin
					state_q <= ST_ORDER;
				end
				ST_ORDER: begin
					state_q <= (hi_maj == lo_maj) ? ST_IDLE : ST_RUN;
				end
				ST_RUN: begin
					if (out_load && at_last) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: latch, swap axes, order ends, then step.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					amaj_q   <= cmd.start_x;
					amin_q   <= cmd.start_y;
					bmaj_q   <= cmd.end_x;
					bmin_q   <= cmd.end_y;
					colour_q <= cmd.colour;
				end
			end
			ST_DELTA: begin
				steep_q <= steep;
				if (steep) begin
					amaj_q <= amin_q;
					amin_q <= amaj_q;
					bmaj_q <= bmin_q;
					bmin_q <= bmaj_q;
				end
			end
			ST_ORDER: begin
				bmaj_q      <= hi_maj;
				pos_q       <= lo_maj;
				minor_q     <= lo_min;
				dmaj_q      <= hi_maj - lo_maj;
				dmin_q      <= (hi_min > lo_min) ? hi_min - lo_min : lo_min - hi_min;
				step_down_q <= !(hi_min > lo_min);
				err_q       <= '0;
			end
			ST_RUN: begin
				if (out_load) begin
					pos_q <= pos_inc;
					if (minor_step) begin
						minor_q <= minor_next;
						err_q   <= err_add - dmaj2;
					end else begin
						err_q   <= err_add;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: load a pixel when free, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (out_load) begin
			pix_valid_q <= 1'b1;
		end else if (pix.ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_x_q      <= steep_q ? minor_q : pos_q;
			pix_y_q      <= steep_q ? pos_q : minor_q;
			pix_colour_q <= colour_q;
			pix_last_q   <= at_last;
		end
	end

	assign pix.valid        = pix_valid_q;
	assign pix.pixel_x      = pix_x_q;
	assign pix.pixel_y      = pix_y_q;
	assign pix.pixel_colour = pix_colour_q;
	assign pix.last_pixel   = pix_last_q;

	`LPR_ASSERT(a_run_pos_below_end, (state_q == ST_RUN) |-> (pos_q < bmaj_q))
	`LPR_ASSERT(a_run_err_bounded, (state_q == ST_RUN) |-> ((err_q <= dmaj_ext) && (err_q > -dmaj_ext)))
	`LPR_ASSERT_NEXT(a_last_ends_run, out_load && at_last, state_q == ST_IDLE)
	`LPR_ASSERT_NEXT(a_cmd_starts_setup, cmd_fire, state_q == ST_DELTA)

endmodule

`default_nettype wire
